// File: rtl/assert_macros.svh
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/escp_pkg.sv
package escp_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int FRAC_W    = 16;
  localparam int FV_W      = SAMPLE_W + FRAC_W;
  localparam int ACC_W     = FV_W + FRAC_W;
  localparam int ALPHA_W   = FRAC_W + 1;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int ADJ_W     = 30;
  localparam int LEVEL_W   = 32;
  localparam int SPAN_W    = CFG_W;
  localparam int MUL_A_W   = FV_W + 1;
  localparam int MUL_B_W   = CFG_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int Q_W       = 15;
  localparam int NUM_W     = SPAN_W + Q_W;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int LVL_SHIFT = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;
  localparam logic [Q_W-1:0]     PCT_FULL  = Q_W'(25600);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA,
    CFG_GAIN,
    CFG_BASE_OFS,
    CFG_EXTRA_OFS,
    CFG_RANGE_LOW,
    CFG_RANGE_HIGH
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMA1,
    S_EMA2,
    S_EMA3,
    S_LMUL,
    S_LADD,
    S_PPREP,
    S_PMUL,
    S_DIVINIT,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_EMA_OLD,
    MUL_EMA_NEW,
    MUL_GAIN,
    MUL_PCT
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_latch;
    logic     ema_update;
    logic     adj_en;
    logic     prep_en;
    logic     div_init;
    logic     div_step;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } stat_t;

endpackage

// File: rtl/ema_scale_clamp_percent_unit.sv
// raw or fault mode: EMA, gain and offsets, range prep, percent multiply;
// percent mode adds the radix-2 percent divider (15-bit quotient)
// one word at a time: in_stall is high until idle again; the 29x25 multiplier
// is shared; a finished word waits while the output register holds an untaken one
// reset (synchronous, rst high): configuration registers to their defaults, filter empty,
// output word dropped; no clearing pass
module ema_scale_clamp_percent_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [escp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [escp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [escp_pkg::SAMPLE_W-1:0]       raw_sample,
  input  logic                                read_ok,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [escp_pkg::LEVEL_W-1:0] level,
  output logic                                is_percent,
  output logic                                range_fault
);

  escp_pkg::cmd_t  cmd;
  escp_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  escp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  escp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .raw_sample  (raw_sample),
    .read_ok     (read_ok),
    .restart     (restart),
    .cmd         (cmd),
    .stat        (stat),
    .level       (level),
    .is_percent  (is_percent),
    .range_fault (range_fault)
  );

endmodule

// File: rtl/escp_dp.sv
module escp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [escp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [escp_pkg::CFG_W-1:0]          cfg_data,
  input  logic [escp_pkg::SAMPLE_W-1:0]       raw_sample,
  input  logic                                read_ok,
  input  logic                                restart,
  input  escp_pkg::cmd_t                      cmd,
  output escp_pkg::stat_t                     stat,
  output logic signed [escp_pkg::LEVEL_W-1:0] level,
  output logic                                is_percent,
  output logic                                range_fault
);

  localparam int CFG_W   = escp_pkg::CFG_W;
  localparam int ADJ_W   = escp_pkg::ADJ_W;
  localparam int PROD_W  = escp_pkg::PROD_W;
  localparam int SPAN_W  = escp_pkg::SPAN_W;
  localparam int Q_W     = escp_pkg::Q_W;
  localparam int NUM_W   = escp_pkg::NUM_W;
  localparam int FV_W    = escp_pkg::FV_W;
  localparam int ACC_W   = escp_pkg::ACC_W;
  localparam int FRAC_W  = escp_pkg::FRAC_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (escp_pkg::LVL_SHIFT - 1);
  localparam logic [ACC_W:0]    EMA_HALF   = (ACC_W + 1)'(1) << (FRAC_W - 1);

  // configuration registers
  logic [escp_pkg::ALPHA_W-1:0] alpha;
  logic signed [CFG_W-1:0]      gain;
  logic signed [CFG_W-1:0]      base_ofs;
  logic signed [CFG_W-1:0]      extra_ofs;
  logic signed [CFG_W-1:0]      range_low;
  logic signed [CFG_W-1:0]      range_high;

  // item and filter state
  logic [escp_pkg::SAMPLE_W-1:0] raw_q;
  logic                          ok_q;
  logic [FV_W-1:0]               fv;
  logic                          filled;

  // datapath registers
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc;
  logic signed [ADJ_W-1:0]  adj;
  logic                     raw_mode;
  logic                     fault;
  logic                     invert;
  logic [SPAN_W-1:0]        diff;
  logic [SPAN_W-1:0]        den;
  logic [SPAN_W-1:0]        div_rem;
  logic [Q_W-1:0]           div_q;

  // combinational values
  logic [escp_pkg::ALPHA_W-1:0] a_eff;
  logic [FV_W-1:0]              vv;
  logic signed [escp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [escp_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic [ACC_W:0]               ema_sum;
  logic [FV_W-1:0]              ema_new;
  logic signed [PROD_W-1:0]     rnd;
  logic signed [PROD_W-1:0]     rnd_sh;
  logic signed [ADJ_W-1:0]      adj_next;
  logic signed [CFG_W-1:0]      lo;
  logic signed [CFG_W-1:0]      hi;
  logic signed [ADJ_W-1:0]      lo_e;
  logic signed [ADJ_W-1:0]      hi_e;
  logic signed [ADJ_W-1:0]      x;
  logic                         invert_next;
  logic                         raw_mode_next;
  logic [NUM_W-1:0]             num;
  logic [SPAN_W:0]              trial;
  logic                         trial_ge;
  logic [Q_W-1:0]               pct_clip;
  logic [Q_W-1:0]               pct_fin;

  assign a_eff = (alpha > escp_pkg::ALPHA_ONE) ? escp_pkg::ALPHA_ONE : alpha;
  assign vv    = filled ? fv : '0;

  always_comb begin
    case (cmd.mul_sel)
      escp_pkg::MUL_EMA_OLD: begin
        mul_a = {1'b0, fv};
        mul_b = escp_pkg::MUL_B_W'(escp_pkg::ALPHA_ONE - a_eff);
      end
      escp_pkg::MUL_EMA_NEW: begin
        mul_a = escp_pkg::MUL_A_W'(raw_q);
        mul_b = escp_pkg::MUL_B_W'(a_eff);
      end
      escp_pkg::MUL_GAIN: begin
        mul_a = {1'b0, vv};
        mul_b = {gain[CFG_W-1], gain};
      end
      default: begin
        mul_a = escp_pkg::MUL_A_W'(diff);
        mul_b = escp_pkg::MUL_B_W'(escp_pkg::PCT_FULL);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // old*(1-a) + new*a, rounded half up
  assign ema_sum = {1'b0, acc} + {1'b0, prod[FV_W-1:0], {FRAC_W{1'b0}}} + EMA_HALF;
  assign ema_new = ema_sum[ACC_W-1:FRAC_W];

  // floor of rounded product, then both offsets
  assign rnd      = prod + $signed(ROUND_HALF);
  assign rnd_sh   = rnd >>> escp_pkg::LVL_SHIFT;
  assign adj_next = rnd_sh[ADJ_W-1:0]
                  + {{(ADJ_W-CFG_W){base_ofs[CFG_W-1]}}, base_ofs}
                  + {{(ADJ_W-CFG_W){extra_ofs[CFG_W-1]}}, extra_ofs};

  assign invert_next   = range_low > range_high;
  assign raw_mode_next = (range_low == '0) && (range_high == '0);
  assign lo   = invert_next ? range_high : range_low;
  assign hi   = invert_next ? range_low : range_high;
  assign lo_e = {{(ADJ_W-CFG_W){lo[CFG_W-1]}}, lo};
  assign hi_e = {{(ADJ_W-CFG_W){hi[CFG_W-1]}}, hi};
  assign x    = (adj < lo_e) ? lo_e : ((adj > hi_e) ? hi_e : adj);

  // num stays below den << Q_W, so the top bits start below den
  assign num      = prod[NUM_W-1:0] + NUM_W'(den >> 1);
  assign trial    = {div_rem, div_q[Q_W-1]};
  assign trial_ge = trial >= {1'b0, den};

  assign pct_clip = (div_q > escp_pkg::PCT_FULL) ? escp_pkg::PCT_FULL : div_q;
  assign pct_fin  = invert ? (escp_pkg::PCT_FULL - pct_clip) : pct_clip;

  assign stat.need_div = !raw_mode && !fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= escp_pkg::ALPHA_ONE;
      gain       <= CFG_W'(65536);
      base_ofs   <= '0;
      extra_ofs  <= '0;
      range_low  <= '0;
      range_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        escp_pkg::CFG_ALPHA:      alpha      <= cfg_data[escp_pkg::ALPHA_W-1:0];
        escp_pkg::CFG_GAIN:       gain       <= cfg_data;
        escp_pkg::CFG_BASE_OFS:   base_ofs   <= cfg_data;
        escp_pkg::CFG_EXTRA_OFS:  extra_ofs  <= cfg_data;
        escp_pkg::CFG_RANGE_LOW:  range_low  <= cfg_data;
        escp_pkg::CFG_RANGE_HIGH: range_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (cmd.load_in && restart) begin
      filled <= 1'b0;
    end else if (cmd.ema_update && ok_q) begin
      filled <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_q <= raw_sample;
      ok_q  <= read_ok;
    end
    if (cmd.ema_update && ok_q) begin
      if (filled && (a_eff != escp_pkg::ALPHA_ONE)) begin
        fv <= ema_new;
      end else begin
        fv <= {raw_q, {FRAC_W{1'b0}}};
      end
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.acc_latch) begin
      acc <= prod[ACC_W-1:0];
    end
    if (cmd.adj_en) begin
      adj <= adj_next;
    end
    if (cmd.prep_en) begin
      raw_mode <= raw_mode_next;
      fault    <= !raw_mode_next && (range_low == range_high);
      invert   <= invert_next;
      diff     <= SPAN_W'(x - lo_e);
      den      <= SPAN_W'(hi_e - lo_e);
    end
    if (cmd.div_init) begin
      div_rem <= num[NUM_W-1:Q_W];
      div_q   <= num[Q_W-1:0];
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? SPAN_W'(trial - {1'b0, den}) : trial[SPAN_W-1:0];
      div_q   <= {div_q[Q_W-2:0], trial_ge};
    end
    if (cmd.load_out) begin
      is_percent  <= stat.need_div;
      range_fault <= fault;
      if (raw_mode) begin
        level <= {{(escp_pkg::LEVEL_W-ADJ_W){adj[ADJ_W-1]}}, adj};
      end else if (fault) begin
        level <= '0;
      end else begin
        level <= {{(escp_pkg::LEVEL_W-Q_W){1'b0}}, pct_fin};
      end
    end
  end

endmodule

// File: rtl/escp_ctrl.sv
`include "assert_macros.svh"

module escp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  escp_pkg::stat_t stat,
  output escp_pkg::cmd_t  cmd
);

  escp_pkg::state_t            state;
  escp_pkg::state_t            state_next;
  logic [escp_pkg::CNT_W-1:0]  div_cnt;

  assign in_stall = (state != escp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= escp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      escp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = escp_pkg::S_EMA1;
        end
      end
      escp_pkg::S_EMA1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = escp_pkg::MUL_EMA_OLD;
        state_next  = escp_pkg::S_EMA2;
      end
      escp_pkg::S_EMA2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = escp_pkg::MUL_EMA_NEW;
        cmd.acc_latch = 1'b1;
        state_next    = escp_pkg::S_EMA3;
      end
      escp_pkg::S_EMA3: begin
        cmd.ema_update = 1'b1;
        state_next     = escp_pkg::S_LMUL;
      end
      escp_pkg::S_LMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = escp_pkg::MUL_GAIN;
        state_next  = escp_pkg::S_LADD;
      end
      escp_pkg::S_LADD: begin
        cmd.adj_en = 1'b1;
        state_next = escp_pkg::S_PPREP;
      end
      escp_pkg::S_PPREP: begin
        cmd.prep_en = 1'b1;
        state_next  = escp_pkg::S_PMUL;
      end
      escp_pkg::S_PMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = escp_pkg::MUL_PCT;
        // raw level and range fault need no division
        state_next  = stat.need_div ? escp_pkg::S_DIVINIT : escp_pkg::S_DONE;
      end
      escp_pkg::S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_next   = escp_pkg::S_DIV;
      end
      escp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == escp_pkg::CNT_W'(escp_pkg::DIV_STEPS - 1)) begin
          state_next = escp_pkg::S_DONE;
        end
      end
      escp_pkg::S_DONE: begin
        // wait here while the previous word is still held
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = escp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = escp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_CLK(a_accept_start, clk, rst, (in_valid && !in_stall) |=> (state == escp_pkg::S_EMA1), "accept did not start")
  `ASSERT_CLK(a_out_from_done, clk, rst, $rose(out_valid) |-> ($past(state) == escp_pkg::S_DONE), "stray output word")
  `ASSERT_CLK(a_div_bound, clk, rst, (state == escp_pkg::S_DIV) |-> (div_cnt < escp_pkg::DIV_STEPS), "divider overrun")
  `ASSERT_CLK(a_done_hold, clk, rst, (state == escp_pkg::S_DONE && out_valid && out_stall) |=> (state == escp_pkg::S_DONE), "held word overwritten")
  `ASSERT_NR(a_reset_clear, clk, rst |=> (!out_valid && state == escp_pkg::S_IDLE), "reset did not clear")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_W  = escp_pkg::SAMPLE_W;
  localparam int FRAC_W    = escp_pkg::FRAC_W;
  localparam int FV_W      = escp_pkg::FV_W;
  localparam int ALPHA_W   = escp_pkg::ALPHA_W;
  localparam int CFG_W     = escp_pkg::CFG_W;
  localparam int CFG_IDX_W = escp_pkg::CFG_IDX_W;
  localparam int LEVEL_W   = escp_pkg::LEVEL_W;
  localparam int LVL_SHIFT = escp_pkg::LVL_SHIFT;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      is_pct;
    logic                      fault;
  } level_word_t;

  localparam int LONG_HOLD_CYCLES = 300;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_W-1:0]       raw_sample = '0;
  logic                      read_ok = 1'b0;
  logic                      restart = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [LEVEL_W-1:0] level;
  logic                      is_percent;
  logic                      range_fault;

  // shadow copy of the registers and the filter
  logic [ALPHA_W-1:0]       alpha_q = escp_pkg::ALPHA_ONE;
  logic signed [CFG_W-1:0]  gain_q = 24'sh010000;
  logic signed [CFG_W-1:0]  base_q = '0;
  logic signed [CFG_W-1:0]  extra_q = '0;
  logic signed [CFG_W-1:0]  low_q = '0;
  logic signed [CFG_W-1:0]  high_q = '0;
  logic [FV_W-1:0]          smoothed = '0;
  logic                     smoothed_full = 1'b0;

  level_word_t expected_words[$];

  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit long_hold = 1'b0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int pct_seen = 0;
  int fault_seen = 0;
  int setups = 0;

  ema_scale_clamp_percent_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_sample (raw_sample),
    .read_ok    (read_ok),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .level      (level),
    .is_percent (is_percent),
    .range_fault(range_fault)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // advance the filter and work out the level word for one sample
  function automatic level_word_t smooth_and_scale(logic [SAMPLE_W-1:0] raw, logic ok,
                                                   logic clr);
    longint unsigned a;
    longint unsigned acc;
    longint unsigned sample;
    longint v;
    longint adj;
    longint lo;
    longint hi;
    longint x;
    longint den;
    longint num;
    longint p;
    level_word_t w;
    a = (alpha_q > escp_pkg::ALPHA_ONE) ? longint'(escp_pkg::ALPHA_ONE) : longint'(alpha_q);
    w = '0;
    if (clr) smoothed_full = 1'b0;
    if (ok) begin
      sample = longint'(raw) << FRAC_W;
      if (!smoothed_full || a == longint'(escp_pkg::ALPHA_ONE)) begin
        smoothed = sample[FV_W-1:0];
      end else begin
        acc = longint'(smoothed) * (longint'(escp_pkg::ALPHA_ONE) - a) + sample * a + 32768;
        smoothed = acc[FRAC_W +: FV_W];
      end
      smoothed_full = 1'b1;
    end
    v = smoothed_full ? longint'(smoothed) : 0;
    adj = ((v * longint'(gain_q)) + longint'(1 << 23)) >>> LVL_SHIFT;
    adj = adj + longint'(base_q) + longint'(extra_q);
    if (low_q == 0 && high_q == 0) begin
      w.level = adj[LEVEL_W-1:0];
    end else if (low_q == high_q) begin
      w.fault = 1'b1;
    end else begin
      lo = (low_q < high_q) ? longint'(low_q) : longint'(high_q);
      hi = (low_q < high_q) ? longint'(high_q) : longint'(low_q);
      x = (adj < lo) ? lo : ((adj > hi) ? hi : adj);
      den = hi - lo;
      num = (x - lo) * longint'(escp_pkg::PCT_FULL) + den / 2;
      p = num / den;
      if (p > longint'(escp_pkg::PCT_FULL)) p = longint'(escp_pkg::PCT_FULL);
      // reversed bounds count down from full scale
      if (low_q > high_q) p = longint'(escp_pkg::PCT_FULL) - p;
      w.level = p[LEVEL_W-1:0];
      w.is_pct = 1'b1;
    end
    return w;
  endfunction

  // result side: compare every accepted word against the oldest prediction
  always @(posedge clk) begin
    level_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected word level %0d pct %0b fault %0b",
                   level, is_percent, range_fault);
      end else begin
        want = expected_words.pop_front();
        if (level !== want.level || is_percent !== want.is_pct ||
            range_fault !== want.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"tb: word %0d mismatch: expected level %0d pct %0b fault %0b,",
                      " got level %0d pct %0b fault %0b"},
                     words_checked, want.level, want.is_pct, want.fault,
                     level, is_percent, range_fault);
        end
        if (want.is_pct) pct_seen++;
        if (want.fault) fault_seen++;
        words_checked++;
      end
    end
  end

  // receiver hold-offs
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // valid stays high after acceptance; the next call or wait_drained replaces it
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic ok,
                             input logic clr);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_sample <= raw;
    read_ok    <= ok;
    restart    <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.insert(expected_words.size(), smooth_and_scale(raw, ok, clr));
    words_sent++;
  endtask

  task automatic send_random_sample();
    logic [SAMPLE_W-1:0] raw;
    if ($urandom_range(0, 7) == 0)
      raw = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    else
      raw = SAMPLE_W'($urandom);
    send_sample(raw, $urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input escp_pkg::cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      escp_pkg::CFG_ALPHA:      alpha_q = data[ALPHA_W-1:0];
      escp_pkg::CFG_GAIN:       gain_q = data;
      escp_pkg::CFG_BASE_OFS:   base_q = data;
      escp_pkg::CFG_EXTRA_OFS:  extra_q = data;
      escp_pkg::CFG_RANGE_LOW:  low_q = data;
      escp_pkg::CFG_RANGE_HIGH: high_q = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] alpha, input logic [CFG_W-1:0] gain,
                              input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] extra,
                              input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    wait_drained();
    write_reg(escp_pkg::CFG_ALPHA, alpha);
    write_reg(escp_pkg::CFG_GAIN, gain);
    write_reg(escp_pkg::CFG_BASE_OFS, base);
    write_reg(escp_pkg::CFG_EXTRA_OFS, extra);
    write_reg(escp_pkg::CFG_RANGE_LOW, lo);
    write_reg(escp_pkg::CFG_RANGE_HIGH, hi);
    cfg_valid <= 1'b0;
    setups++;
  endtask

  // power-up registers: raw mode, no smoothing, empty filter
  task automatic test_reset_defaults();
    send_sample(12'h000, 1'b0, 1'b0);
    send_sample(12'hFFF, 1'b1, 1'b0);
    send_sample(12'h000, 1'b0, 1'b1);
    send_sample(12'hA5A, 1'b1, 1'b1);
  endtask

  task automatic test_smoothing();
    // zero weight: the first sample loads, later ones are ignored
    program_regs(24'h000000, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0);
    send_sample(12'hFFF, 1'b1, 1'b1);
    send_sample(12'h000, 1'b1, 1'b0);
    program_regs(24'h008000, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0);
    send_sample(12'h000, 1'b1, 1'b0);
    send_sample(12'h001, 1'b1, 1'b0);
    // weight above one behaves as one
    program_regs(24'h01FFFF, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0);
    send_sample(12'h07B, 1'b1, 1'b0);
  endtask

  task automatic test_scaling_extremes();
    program_regs(24'h010000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h0);
    send_sample(12'hFFF, 1'b1, 1'b0);
    program_regs(24'h010000, 24'h800000, 24'h800000, 24'h800000, 24'h0, 24'h0);
    send_sample(12'hFFF, 1'b1, 1'b0);
  endtask

  task automatic test_range_mapping();
    program_regs(24'h010000, 24'h010000, 24'h0, 24'h0, 24'd1000, 24'd1000);
    send_sample(12'h123, 1'b1, 1'b0);
    program_regs(24'h010000, 24'h010000, 24'h0, 24'h0, 24'd25600, 24'd256000);
    send_sample(12'd50, 1'b1, 1'b0);
    send_sample(12'd500, 1'b1, 1'b0);
    send_sample(12'hFFF, 1'b1, 1'b0);
    // reversed bounds
    program_regs(24'h010000, 24'h010000, 24'h0, 24'h0, 24'd256000, 24'd25600);
    send_sample(12'd500, 1'b1, 1'b0);
    program_regs(24'h010000, 24'h010000, 24'h0, 24'h0, 24'h800000, 24'h7FFFFF);
    send_sample(12'hFFF, 1'b1, 1'b0);
    program_regs(24'h010000, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h7FFFFF);
    send_sample(12'h000, 1'b1, 1'b0);
  endtask

  // receiver stops for a long stretch while words keep coming
  task automatic test_output_hold();
    program_regs(24'h004000, 24'h010000, 24'h0, 24'h0, 24'd100000, 24'd900000);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    long_hold = 1'b1;
    for (int k = 0; k < 16; k++) send_random_sample();
  endtask

  task automatic random_setup();
    logic [CFG_W-1:0] alpha;
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] extra;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    case ($urandom_range(0, 5))
      0:       alpha = 24'h000000;
      1:       alpha = 24'h010000;
      2:       alpha = CFG_W'($urandom_range(65537, 131071));
      3:       alpha = CFG_W'($urandom_range(1, 65535));
      default: alpha = CFG_W'($urandom_range(1024, 16384));
    endcase
    case ($urandom_range(0, 4))
      0:       gain = 24'h010000;
      1:       gain = 24'h7FFFFF;
      2:       gain = 24'h800000;
      3:       gain = CFG_W'($urandom);
      default: gain = CFG_W'($urandom_range(0, 262144));
    endcase
    base  = ($urandom_range(0, 2) == 0) ? 24'h0 : 24'($urandom);
    extra = ($urandom_range(0, 2) == 0) ? 24'h0 : 24'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        lo = '0;
        hi = '0;
      end
      1: begin
        lo = CFG_W'($urandom_range(1, 24'hFFFFFF));
        hi = lo;
      end
      2: begin
        lo = CFG_W'($urandom);
        hi = CFG_W'($urandom);
      end
      default: begin
        // bounds inside the span that unity gain produces
        gain  = 24'h010000;
        base  = CFG_W'($urandom_range(0, 4096));
        extra = CFG_W'($urandom_range(0, 4096));
        lo = CFG_W'($urandom_range(0, 1048320));
        hi = CFG_W'($urandom_range(0, 1048320));
      end
    endcase
    program_regs(alpha, gain, base, extra, lo, hi);
  endtask

  task automatic test_random_traffic();
    int n;
    for (int ph = 0; ph < 13; ph++) begin
      random_setup();
      // last phase runs with no idling on either side
      tx_gaps = (ph < 12) && ($urandom_range(0, 3) != 0);
      rx_gaps = (ph < 12) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(80, 120);
      for (int k = 0; k < n; k++) send_random_sample();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_smoothing();
    test_scaling_extremes();
    test_range_mapping();
    test_output_hold();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    if (expected_words.size() != 0) mismatches++;
    $display("tb: %0d samples sent, %0d words checked over %0d register setups",
             words_sent, words_checked, setups);
    $display("tb: %0d percent words, %0d range faults, %0d mismatches",
             pct_seen, fault_seen, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/escp_pkg.sv
rtl/escp_dp.sv
rtl/escp_ctrl.sv
rtl/ema_scale_clamp_percent_unit.sv
sim/testbench.sv
